>>> hdl/ps2mc_pkg.sv
// Shared types, constants and the move scaling function for the PS/2 cursor block.
package ps2mc_pkg;

    localparam int COORD_BITS   = 12;
    localparam int MOVE_DIVISOR = 15;

    localparam int REG_W   = 12;
    localparam int OUT_W   = 12;
    localparam int BYTE_W  = 8;
    localparam int MAG_W   = BYTE_W + 1;
    localparam int DELTA_W = MAG_W + 1;
    localparam int LIM_W   = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;
    localparam int SUM_W   = ((COORD_BITS > DELTA_W) ? COORD_BITS : DELTA_W) + 2;

    // reciprocal for the divide by constant, exact over the nine-bit magnitude range
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + MOVE_DIVISOR - 1) / MOVE_DIVISOR;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    localparam logic [REG_W-1:0] X_LIMIT_RST = REG_W'(639);
    localparam logic [REG_W-1:0] Y_LIMIT_RST = REG_W'(479);

    localparam logic [BYTE_W-1:0] ACK_BYTE = 8'hFA;
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;
    localparam int HDR_XOVF   = 6;
    localparam int HDR_YOVF   = 7;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LIMIT = 1'b0,
        CFG_Y_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } phase_t;

    typedef logic [MAG_W-1:0] mag_t;

    // received word with both candidate quotients, sign chosen later from the header
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        mag_t              q_pos;
        mag_t              q_neg;
    } rx_word_t;

    function automatic mag_t div_mag(input mag_t m);
        logic [MAG_W+RECIP_W-1:0] prod;
        prod = {{RECIP_W{1'b0}}, m} * {{MAG_W{1'b0}}, RECIP_W'(RECIP)};
        return prod[RECIP_SHIFT +: MAG_W];
    endfunction

endpackage

>>> hdl/ps2mc_scale.sv
// Input stage scaling: byte magnitudes divided by the move divisor for both signs.
module ps2mc_scale
(
    input  logic [ps2mc_pkg::BYTE_W-1:0] data,
    output ps2mc_pkg::rx_word_t          word
);

    ps2mc_pkg::mag_t mag_pos;
    ps2mc_pkg::mag_t mag_neg;

    assign mag_pos = {1'b0, data};
    // negative nine-bit value has magnitude 256 - byte
    assign mag_neg = ps2mc_pkg::mag_t'(2 ** ps2mc_pkg::BYTE_W) - {1'b0, data};

    assign word.data  = data;
    assign word.q_pos = ps2mc_pkg::div_mag(mag_pos);
    assign word.q_neg = ps2mc_pkg::div_mag(mag_neg);

endmodule

>>> hdl/ps2mc_axis.sv
// One cursor axis: add signed step and clamp to 0..limit.
module ps2mc_axis
(
    input  logic [ps2mc_pkg::COORD_BITS-1:0]     pos,
    input  logic signed [ps2mc_pkg::DELTA_W-1:0] delta,
    input  logic [ps2mc_pkg::REG_W-1:0]          limit,
    output logic [ps2mc_pkg::COORD_BITS-1:0]     pos_new
);

    logic [ps2mc_pkg::COORD_BITS-1:0] lim_eff;
    logic [ps2mc_pkg::SUM_W-1:0]      sum;
    logic [ps2mc_pkg::SUM_W-1:0]      lim_ext;

    always_comb
    begin
        if (ps2mc_pkg::LIM_W'(limit) > ps2mc_pkg::LIM_W'(ps2mc_pkg::COORD_MAX))
        begin
            lim_eff = ps2mc_pkg::COORD_MAX;
        end
        else
        begin
            lim_eff = ps2mc_pkg::COORD_BITS'(ps2mc_pkg::LIM_W'(limit));
        end
    end

    assign sum = {{(ps2mc_pkg::SUM_W - ps2mc_pkg::COORD_BITS){1'b0}}, pos}
               + {{(ps2mc_pkg::SUM_W - ps2mc_pkg::DELTA_W){delta[ps2mc_pkg::DELTA_W-1]}}, delta};
    assign lim_ext = {{(ps2mc_pkg::SUM_W - ps2mc_pkg::COORD_BITS){1'b0}}, lim_eff};

    always_comb
    begin
        if (sum[ps2mc_pkg::SUM_W-1])
        begin
            pos_new = '0;
        end
        else if (sum > lim_ext)
        begin
            pos_new = lim_eff;
        end
        else
        begin
            pos_new = sum[ps2mc_pkg::COORD_BITS-1:0];
        end
    end

endmodule

>>> hdl/ps2_mouse_packet_cursor_top.sv
// Top level of the PS/2 mouse packet decoder with clamped cursor.
// Takes one received byte per cycle on in_valid/in_ready and groups bytes into
// three-byte packets (header, dx, dy); a 0xFA acknowledge in place of a header is
// dropped. Each packet without overflow bits gives one word on out_valid/out_ready
// carrying the new and previous cursor and the button states; packets with an
// overflow bit are swallowed whole. A packet's result is registered from its last
// byte in the input register. in_ready drops only while both the input register
// and the result register are full and the result is not being taken. The user
// writes x_limit and y_limit through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce it.
module ps2_mouse_packet_cursor_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [ps2mc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ps2mc_pkg::REG_W-1:0]          cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ps2mc_pkg::BYTE_W-1:0]         rx_byte,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ps2mc_pkg::OUT_W-1:0]          pos_x,
    output logic [ps2mc_pkg::OUT_W-1:0]          pos_y,
    output logic [ps2mc_pkg::OUT_W-1:0]          old_x,
    output logic [ps2mc_pkg::OUT_W-1:0]          old_y,
    output logic                                 left_down,
    output logic                                 right_down,
    output logic                                 middle_down
);

    logic [ps2mc_pkg::REG_W-1:0] x_limit_reg;
    logic [ps2mc_pkg::REG_W-1:0] y_limit_reg;

    ps2mc_pkg::rx_word_t rx_word;
    ps2mc_pkg::rx_word_t s1_reg;
    logic                s1_valid_reg;
    logic                s1_valid_next;

    ps2mc_pkg::phase_t phase_reg;
    ps2mc_pkg::phase_t phase_next;

    logic [ps2mc_pkg::BYTE_W-1:0]         header_reg;
    logic [ps2mc_pkg::BYTE_W-1:0]         header_next;
    logic signed [ps2mc_pkg::DELTA_W-1:0] dx_delta_reg;
    logic signed [ps2mc_pkg::DELTA_W-1:0] dx_delta_next;
    logic signed [ps2mc_pkg::DELTA_W-1:0] dy_delta;
    logic [ps2mc_pkg::COORD_BITS-1:0]     cursor_x_reg;
    logic [ps2mc_pkg::COORD_BITS-1:0]     cursor_y_reg;
    logic [ps2mc_pkg::COORD_BITS-1:0]     cursor_x_new;
    logic [ps2mc_pkg::COORD_BITS-1:0]     cursor_y_new;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [ps2mc_pkg::OUT_W-1:0]  pos_x_reg;
    logic [ps2mc_pkg::OUT_W-1:0]  pos_y_reg;
    logic [ps2mc_pkg::OUT_W-1:0]  old_x_reg;
    logic [ps2mc_pkg::OUT_W-1:0]  old_y_reg;
    logic [2:0]                   buttons_reg;

    logic advance;
    logic in_take;
    logic proc;
    logic produce;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= ps2mc_pkg::X_LIMIT_RST;
            y_limit_reg <= ps2mc_pkg::Y_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (ps2mc_pkg::cfg_idx_t'(cfg_index))
                ps2mc_pkg::CFG_X_LIMIT: x_limit_reg <= cfg_data;
                ps2mc_pkg::CFG_Y_LIMIT: y_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: the result register parts the two sides
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;
    assign proc     = s1_valid_reg && advance;

    ps2mc_scale u_scale
    (
        .data (rx_byte),
        .word (rx_word)
    );

    assign s1_valid_next = in_ready ? in_valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_reg <= rx_word;
        end
    end

    // packet phase
    always_comb
    begin
        phase_next = phase_reg;
        if (proc)
        begin
            case (phase_reg)
                ps2mc_pkg::PH_DX: phase_next = ps2mc_pkg::PH_DY;
                ps2mc_pkg::PH_DY: phase_next = ps2mc_pkg::PH_HEADER;
                default:
                begin
                    if (s1_reg.data == ps2mc_pkg::ACK_BYTE)
                    begin
                        phase_next = ps2mc_pkg::PH_HEADER;
                    end
                    else
                    begin
                        phase_next = ps2mc_pkg::PH_DX;
                    end
                end
            endcase
        end
    end

    // y is negated: positive mouse y moves the cursor up
    assign dy_delta = header_reg[ps2mc_pkg::HDR_YSIGN]
                    ? $signed({1'b0, s1_reg.q_neg})
                    : -$signed({1'b0, s1_reg.q_pos});

    ps2mc_axis u_axis_x
    (
        .pos     (cursor_x_reg),
        .delta   (dx_delta_reg),
        .limit   (x_limit_reg),
        .pos_new (cursor_x_new)
    );

    ps2mc_axis u_axis_y
    (
        .pos     (cursor_y_reg),
        .delta   (dy_delta),
        .limit   (y_limit_reg),
        .pos_new (cursor_y_new)
    );

    always_comb
    begin
        header_next   = header_reg;
        dx_delta_next = dx_delta_reg;
        produce       = 1'b0;
        if (proc)
        begin
            case (phase_reg)
                ps2mc_pkg::PH_DX:
                begin
                    dx_delta_next = header_reg[ps2mc_pkg::HDR_XSIGN]
                                  ? -$signed({1'b0, s1_reg.q_neg})
                                  : $signed({1'b0, s1_reg.q_pos});
                end
                ps2mc_pkg::PH_DY:
                begin
                    produce = !(header_reg[ps2mc_pkg::HDR_XOVF]
                             || header_reg[ps2mc_pkg::HDR_YOVF]);
                end
                default:
                begin
                    if (s1_reg.data != ps2mc_pkg::ACK_BYTE)
                    begin
                        header_next = s1_reg.data;
                    end
                end
            endcase
        end
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ps2mc_pkg::PH_HEADER;
            header_reg    <= '0;
            dx_delta_reg  <= '0;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            header_reg    <= header_next;
            dx_delta_reg  <= dx_delta_next;
            out_valid_reg <= out_valid_next;
            if (produce)
            begin
                cursor_x_reg <= cursor_x_new;
                cursor_y_reg <= cursor_y_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            pos_x_reg   <= ps2mc_pkg::OUT_W'(cursor_x_new);
            pos_y_reg   <= ps2mc_pkg::OUT_W'(cursor_y_new);
            old_x_reg   <= ps2mc_pkg::OUT_W'(cursor_x_reg);
            old_y_reg   <= ps2mc_pkg::OUT_W'(cursor_y_reg);
            buttons_reg <= {header_reg[ps2mc_pkg::HDR_MIDDLE],
                            header_reg[ps2mc_pkg::HDR_RIGHT],
                            header_reg[ps2mc_pkg::HDR_LEFT]};
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign old_x       = old_x_reg;
    assign old_y       = old_y_reg;
    assign left_down   = buttons_reg[0];
    assign right_down  = buttons_reg[1];
    assign middle_down = buttons_reg[2];

endmodule

>>> hdl/ps2mc_checker.sv
// Port-level checks for the PS/2 cursor block, bound to the top level.
module ps2mc_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_we,
    input logic [ps2mc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [ps2mc_pkg::REG_W-1:0]      cfg_data,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [ps2mc_pkg::OUT_W-1:0]      pos_x,
    input logic [ps2mc_pkg::OUT_W-1:0]      pos_y,
    input logic [ps2mc_pkg::OUT_W-1:0]      old_x,
    input logic [ps2mc_pkg::OUT_W-1:0]      old_y
);

    logic                        seen_reg;
    logic [ps2mc_pkg::OUT_W-1:0] last_x_reg;
    logic [ps2mc_pkg::OUT_W-1:0] last_y_reg;
    logic [ps2mc_pkg::REG_W-1:0] lim_x_reg;
    logic [ps2mc_pkg::REG_W-1:0] lim_y_reg;
    logic                        out_take;

    assign out_take = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= 1'b0;
            last_x_reg <= '0;
            last_y_reg <= '0;
            lim_x_reg  <= ps2mc_pkg::X_LIMIT_RST;
            lim_y_reg  <= ps2mc_pkg::Y_LIMIT_RST;
        end
        else
        begin
            if (out_take)
            begin
                seen_reg   <= 1'b1;
                last_x_reg <= pos_x;
                last_y_reg <= pos_y;
            end
            if (cfg_we && cfg_index == ps2mc_pkg::CFG_X_LIMIT)
            begin
                lim_x_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == ps2mc_pkg::CFG_Y_LIMIT)
            begin
                lim_y_reg <= cfg_data;
            end
        end
    end

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
            && $stable(old_x) && $stable(old_y))
        else $error("result changed while stalled");

    // each packet starts where the previous one left the cursor
    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && seen_reg |-> old_x == last_x_reg && old_y == last_y_reg)
        else $error("previous cursor does not match last result");

    // clamped cursor never exceeds its limit
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pos_x <= lim_x_reg && pos_y <= lim_y_reg)
        else $error("cursor beyond limit");

    // with the result register empty the input side is never blocked
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

bind ps2_mouse_packet_cursor_top ps2mc_checker u_ps2mc_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the PS/2 mouse packet decoder with clamped cursor.
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 8;
    localparam int N_DIRECTED  = 25;
    // limit table codes: pick at random, or pick at or below the current cursor
    localparam int LIM_RANDOM  = -1;
    localparam int LIM_BELOW   = -2;

    typedef struct packed {
        logic [ps2mc_pkg::OUT_W-1:0] pos_x;
        logic [ps2mc_pkg::OUT_W-1:0] pos_y;
        logic [ps2mc_pkg::OUT_W-1:0] old_x;
        logic [ps2mc_pkg::OUT_W-1:0] old_y;
        logic                        btn_l;
        logic                        btn_r;
        logic                        btn_m;
    } cursor_word_t;

    typedef struct {
        logic [ps2mc_pkg::BYTE_W-1:0] b;
        bit                           typed;
        cursor_word_t                 want;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [ps2mc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ps2mc_pkg::REG_W-1:0]     cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [ps2mc_pkg::BYTE_W-1:0]    rx_byte = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [ps2mc_pkg::OUT_W-1:0]     pos_x, pos_y, old_x, old_y;
    logic                            left_down, right_down, middle_down;

    ps2_mouse_packet_cursor_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .old_x       (old_x),
        .old_y       (old_y),
        .left_down   (left_down),
        .right_down  (right_down),
        .middle_down (middle_down)
    );

    always #4 clk = ~clk;

    // cursor model state
    ps2mc_pkg::phase_t            pkt_phase = ps2mc_pkg::PH_HEADER;
    logic [ps2mc_pkg::BYTE_W-1:0] hdr_hold = '0;
    logic [ps2mc_pkg::BYTE_W-1:0] dx_hold = '0;
    logic [ps2mc_pkg::OUT_W-1:0]  cur_x = '0;
    logic [ps2mc_pkg::OUT_W-1:0]  cur_y = '0;
    logic [ps2mc_pkg::REG_W-1:0]  lim_x = ps2mc_pkg::X_LIMIT_RST;
    logic [ps2mc_pkg::REG_W-1:0]  lim_y = ps2mc_pkg::Y_LIMIT_RST;

    cursor_word_t cursor_words_due[$];
    int           n_fail = 0;
    int           bytes_sent = 0;
    int           cycle_cnt = 0;
    bit           tx_steady = 1'b0;
    bit           rx_steady = 1'b0;

    // after reset: limits 639/479, cursor at origin
    stim_row_t dir_rows [N_DIRECTED] = '{
        '{ps2mc_pkg::ACK_BYTE, 1'b0, '0},
        '{8'h08, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, {12'd0, 12'd0, 12'd0, 12'd0, 3'b000}},
        '{8'h0F, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b1, {12'd17, 12'd0, 12'd0, 12'd0, 3'b111}},
        '{8'h28, 1'b0, '0}, '{ps2mc_pkg::ACK_BYTE, 1'b0, '0},
        '{8'h00, 1'b1, {12'd33, 12'd17, 12'd17, 12'd0, 3'b000}},
        '{8'h18, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{ps2mc_pkg::ACK_BYTE, 1'b1, {12'd16, 12'd1, 12'd33, 12'd17, 3'b000}},
        '{8'h48, 1'b0, '0}, '{8'h7F, 1'b0, '0}, '{8'h7F, 1'b0, '0},
        '{8'h87, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h01, 1'b0, '0},
        '{8'h38, 1'b0, '0}, '{8'h01, 1'b0, '0},
        '{8'h01, 1'b1, {12'd0, 12'd18, 12'd16, 12'd1, 3'b000}},
        '{8'h37, 1'b0, '0}, '{8'hF1, 1'b0, '0},
        '{8'hF1, 1'b1, {12'd0, 12'd19, 12'd0, 12'd18, 3'b111}}
    };

    int lx_tab    [N_PHASES] = '{639, 4095, LIM_BELOW, 0, 4095, 0, LIM_RANDOM, 639};
    int ly_tab    [N_PHASES] = '{479, 4095, LIM_BELOW, 0, 0, 4095, LIM_RANDOM, 479};
    int drift_tab [N_PHASES] = '{0, 1, -1, 1, 1, -1, 0, 1};
    int len_tab   [N_PHASES] = '{100, 800, 125, 75, 75, 75, 125, 50};

    function automatic int scaled_move(input logic [ps2mc_pkg::BYTE_W-1:0] low,
                                       input bit neg);
        int v;
        v = int'(low);
        if (neg)
            v -= 256;
        return v / ps2mc_pkg::MOVE_DIVISOR;
    endfunction

    function automatic logic [ps2mc_pkg::OUT_W-1:0] clamp_axis(
            input logic [ps2mc_pkg::OUT_W-1:0] pos,
            input int delta,
            input logic [ps2mc_pkg::REG_W-1:0] lim);
        int s;
        s = int'(pos) + delta;
        if (s < 0)
            return '0;
        if (s > int'(lim))
            return lim;
        return s[ps2mc_pkg::OUT_W-1:0];
    endfunction

    // advances the packet state by one byte; returns 1 when a cursor word is due
    function automatic bit step_cursor(input logic [ps2mc_pkg::BYTE_W-1:0] b,
                                       output cursor_word_t w);
        int mx, my;
        bit due;
        w = '0;
        due = 1'b0;
        case (pkt_phase)
            ps2mc_pkg::PH_DX:
            begin
                dx_hold = b;
                pkt_phase = ps2mc_pkg::PH_DY;
            end
            ps2mc_pkg::PH_DY:
            begin
                pkt_phase = ps2mc_pkg::PH_HEADER;
                if (!hdr_hold[ps2mc_pkg::HDR_XOVF] && !hdr_hold[ps2mc_pkg::HDR_YOVF])
                begin
                    mx = scaled_move(dx_hold, hdr_hold[ps2mc_pkg::HDR_XSIGN]);
                    my = -scaled_move(b, hdr_hold[ps2mc_pkg::HDR_YSIGN]);
                    w.old_x = cur_x;
                    w.old_y = cur_y;
                    cur_x = clamp_axis(cur_x, mx, lim_x);
                    cur_y = clamp_axis(cur_y, my, lim_y);
                    w.pos_x = cur_x;
                    w.pos_y = cur_y;
                    w.btn_l = hdr_hold[ps2mc_pkg::HDR_LEFT];
                    w.btn_r = hdr_hold[ps2mc_pkg::HDR_RIGHT];
                    w.btn_m = hdr_hold[ps2mc_pkg::HDR_MIDDLE];
                    due = 1'b1;
                end
            end
            default:
            begin
                pkt_phase = ps2mc_pkg::PH_HEADER;
                if (b != ps2mc_pkg::ACK_BYTE)
                begin
                    hdr_hold = b;
                    pkt_phase = ps2mc_pkg::PH_DX;
                end
            end
        endcase
        return due;
    endfunction

    // valid is left high after acceptance; it drops only when a gap or a pause follows
    task automatic send_byte(input logic [ps2mc_pkg::BYTE_W-1:0] b, input bit typed,
                             input cursor_word_t want);
        int gap;
        cursor_word_t w;
        gap = tx_steady ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 39) == 0)
            tx_steady = !tx_steady;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (!in_ready);
        if (!(b == ps2mc_pkg::ACK_BYTE && pkt_phase == ps2mc_pkg::PH_HEADER))
            bytes_sent++;
        if (step_cursor(b, w))
            cursor_words_due.push_back(typed ? want : w);
    endtask

    task automatic send_packet(input int drift);
        logic [ps2mc_pkg::BYTE_W-1:0] hdr, dx, dy;
        // stray byte knocks the framing off
        if ($urandom_range(0, 24) == 0)
            send_byte(ps2mc_pkg::BYTE_W'($urandom), 1'b0, '0);
        if ($urandom_range(0, 9) == 0)
            send_byte(ps2mc_pkg::ACK_BYTE, 1'b0, '0);
        hdr = ps2mc_pkg::BYTE_W'($urandom);
        dx = ps2mc_pkg::BYTE_W'($urandom);
        dy = ps2mc_pkg::BYTE_W'($urandom);
        if ($urandom_range(0, 7) != 0)
            hdr[ps2mc_pkg::HDR_YOVF:ps2mc_pkg::HDR_XOVF] = 2'b00;
        // drift pushes both axes towards the top or bottom of the range
        if (drift != 0 && $urandom_range(0, 7) != 0)
        begin
            hdr[ps2mc_pkg::HDR_XSIGN] = (drift < 0);
            dx = (drift > 0) ? ps2mc_pkg::BYTE_W'($urandom_range(128, 255))
                             : ps2mc_pkg::BYTE_W'($urandom_range(0, 127));
        end
        if (drift != 0 && $urandom_range(0, 7) != 0)
        begin
            hdr[ps2mc_pkg::HDR_YSIGN] = (drift > 0);
            dy = (drift > 0) ? ps2mc_pkg::BYTE_W'($urandom_range(0, 127))
                             : ps2mc_pkg::BYTE_W'($urandom_range(128, 255));
        end
        send_byte(hdr, 1'b0, '0);
        send_byte(dx, 1'b0, '0);
        send_byte(dy, 1'b0, '0);
    endtask

    // hold off until every cursor word is in, plus the pipeline depth
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (cursor_words_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limits(input logic [ps2mc_pkg::REG_W-1:0] x,
                              input logic [ps2mc_pkg::REG_W-1:0] y);
        cfg_we <= 1'b1;
        cfg_index <= ps2mc_pkg::CFG_X_LIMIT;
        cfg_data <= x;
        @(posedge clk);
        cfg_index <= ps2mc_pkg::CFG_Y_LIMIT;
        cfg_data <= y;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_x = x;
        lim_y = y;
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            n_fail++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t run timed out", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int ph, goal, i;
        logic [ps2mc_pkg::REG_W-1:0] lx, ly;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < N_DIRECTED; i++)
            send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                settle();
                lx = (lx_tab[ph] == LIM_RANDOM) ?
                         ps2mc_pkg::REG_W'($urandom_range(0, 4095)) :
                     (lx_tab[ph] == LIM_BELOW)  ?
                         ps2mc_pkg::REG_W'($urandom_range(0, cur_x)) :
                         ps2mc_pkg::REG_W'(lx_tab[ph]);
                ly = (ly_tab[ph] == LIM_RANDOM) ?
                         ps2mc_pkg::REG_W'($urandom_range(0, 4095)) :
                     (ly_tab[ph] == LIM_BELOW)  ?
                         ps2mc_pkg::REG_W'($urandom_range(0, cur_y)) :
                         ps2mc_pkg::REG_W'(ly_tab[ph]);
                set_limits(lx, ly);
            end
            goal = bytes_sent + len_tab[ph];
            while (bytes_sent < goal)
            begin
                send_packet(drift_tab[ph]);
                if ($urandom_range(0, 59) == 0)
                    settle();
            end
        end
        settle();
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls, each word checked against the oldest one due
    initial
    begin
        int stall;
        cursor_word_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_steady ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (cursor_words_due.size() == 0)
            begin
                n_fail++;
                $display("%0t unexpected word: pos %0d,%0d old %0d,%0d", $time,
                         pos_x, pos_y, old_x, old_y);
            end
            else
            begin
                want = cursor_words_due.pop_front();
                check_field("pos_x", want.pos_x, pos_x);
                check_field("pos_y", want.pos_y, pos_y);
                check_field("old_x", want.old_x, old_x);
                check_field("old_y", want.old_y, old_y);
                check_field("left_down", want.btn_l, left_down);
                check_field("right_down", want.btn_r, right_down);
                check_field("middle_down", want.btn_m, middle_down);
            end
        end
    end

endmodule
